FILE: sv/dbt_pkg.sv
package dbt_pkg;

  typedef enum logic [2:0] {
    K_END       = 3'd0,
    K_IDENT     = 3'd1,
    K_ARROW     = 3'd2,
    K_STRING    = 3'd3,
    K_DIRECTIVE = 3'd4,
    K_INT       = 3'd5,
    K_SINGLE    = 3'd6,
    K_UNTERM    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE      = 3'd0,
    M_SLASH     = 3'd1,
    M_COMMENT   = 3'd2,
    M_DASH      = 3'd3,
    M_INT       = 3'd4,
    M_IDENT     = 3'd5,
    M_STRING    = 3'd6,
    M_DIRECTIVE = 3'd7
  } mode_t;

  typedef logic [7:0] byte_t;

  localparam byte_t CH_NUL        = 8'h00;
  localparam byte_t CH_TAB        = 8'h09;
  localparam byte_t CH_NEWLINE    = 8'h0A;
  localparam byte_t CH_VTAB       = 8'h0B;
  localparam byte_t CH_FORMFEED   = 8'h0C;
  localparam byte_t CH_RETURN     = 8'h0D;
  localparam byte_t CH_SPACE      = 8'h20;
  localparam byte_t CH_QUOTE      = 8'h22;
  localparam byte_t CH_HASH       = 8'h23;
  localparam byte_t CH_DASH       = 8'h2D;
  localparam byte_t CH_SLASH      = 8'h2F;
  localparam byte_t CH_ZERO       = 8'h30;
  localparam byte_t CH_NINE       = 8'h39;
  localparam byte_t CH_GREATER    = 8'h3E;
  localparam byte_t CH_UPPER_A    = 8'h41;
  localparam byte_t CH_UPPER_Z    = 8'h5A;
  localparam byte_t CH_UNDERSCORE = 8'h5F;
  localparam byte_t CH_LOWER_A    = 8'h61;
  localparam byte_t CH_LOWER_Z    = 8'h7A;

  function automatic logic is_digit(byte_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_word(byte_t c);
    return is_digit(c) || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_space(byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
           (c == CH_VTAB) || (c == CH_FORMFEED) || (c == CH_RETURN);
  endfunction

endpackage

FILE: sv/dsl_byte_tokenizer_unit.sv
// Streaming lexer: one text byte per request in, tokens out in text order. Whitespace and
// comments give no token; a byte that ends a run, a lone slash or a lone dash can give two
// tokens. The unit takes one byte every cycle while it does not stall: a byte sits in the
// input register, is scanned there and its tokens enter a four-entry result queue, from
// which they are presented. The queue drains one token per cycle while out_stall is low;
// input stalls only while the queue has fewer than two free entries. A zero byte ends the
// text with an end token (inside a string, with an unterminated token instead), and
// offset and line then restart at zero and one.
module dsl_byte_tokenizer_unit #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             text_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output dbt_pkg::kind_t         token_kind,
  output logic [7:0]             char_code,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [OFFSET_BITS-1:0] token_length,
  output logic [LINE_BITS-1:0]   line_number,
  output logic                   last
);

  import dbt_pkg::*;

  localparam int LEN_LO   = LINE_BITS;
  localparam int START_LO = LINE_BITS + OFFSET_BITS;
  localparam int CODE_LO  = LINE_BITS + 2 * OFFSET_BITS;
  localparam int KIND_LO  = CODE_LO + 8;
  localparam int LAST_BIT = KIND_LO + 3;
  localparam int TW       = LAST_BIT + 1;

  // Input register.
  logic  in_full;
  byte_t in_byte;
  logic  accept;
  logic  fire;
  logic  room;

  // Scanner state.
  mode_t                  mode,     mode_next;
  logic [OFFSET_BITS-1:0] tok_start, tok_start_next;
  logic [LINE_BITS-1:0]   tok_line,  tok_line_next;
  logic [OFFSET_BITS-1:0] byte_pos,  byte_pos_next;
  logic [LINE_BITS-1:0]   cur_line,  cur_line_next;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] run_len;
  logic                   fresh;
  logic                   cont;

  logic                   emit_a, emit_b;
  kind_t                  kind_a, kind_b;
  byte_t                  code_a, code_b;
  logic [OFFSET_BITS-1:0] len_a,  len_b;
  logic [TW-1:0]          tok_a,  tok_b;

  logic [1:0]    wr_count;
  logic [TW-1:0] wr_data0;
  logic [TW-1:0] rd_data;
  logic [2:0]    fifo_count;

  function automatic logic [TW-1:0] pack_token(logic lst, kind_t k, byte_t cd,
                                               logic [OFFSET_BITS-1:0] st,
                                               logic [OFFSET_BITS-1:0] ln,
                                               logic [LINE_BITS-1:0] lin);
    return {lst, k, cd, st, ln, lin};
  endfunction

  assign room     = (fifo_count <= 3'd2);
  assign fire     = in_full && room;
  assign in_stall = in_full && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= text_byte;
    end
  end

  assign pos_inc = byte_pos + OFFSET_BITS'(1);
  assign run_len = byte_pos - tok_start;

  always_comb begin
    mode_next      = mode;
    tok_start_next = tok_start;
    tok_line_next  = tok_line;
    byte_pos_next  = byte_pos;
    cur_line_next  = cur_line;
    fresh          = 1'b0;
    cont           = 1'b0;
    emit_a         = 1'b0;
    kind_a         = K_SINGLE;
    code_a         = CH_NUL;
    len_a          = run_len;
    emit_b         = 1'b0;
    kind_b         = K_SINGLE;
    code_b         = CH_NUL;
    len_b          = '0;

    // Token that closes the pending construct, if any.
    unique case (mode)
      M_INT, M_IDENT, M_DIRECTIVE: begin
        cont = (mode == M_INT) ? is_digit(in_byte) : is_word(in_byte);
        if (cont) begin
          byte_pos_next = pos_inc;
        end else begin
          emit_a    = 1'b1;
          kind_a    = (mode == M_INT) ? K_INT : ((mode == M_IDENT) ? K_IDENT : K_DIRECTIVE);
          mode_next = M_IDLE;
          fresh     = 1'b1;
        end
      end
      M_STRING: begin
        if (in_byte == CH_QUOTE) begin
          emit_a        = 1'b1;
          kind_a        = K_STRING;
          len_a         = run_len + OFFSET_BITS'(1);
          byte_pos_next = pos_inc;
          mode_next     = M_IDLE;
        end else if ((in_byte == CH_NUL) || (in_byte == CH_NEWLINE)) begin
          // The terminating byte is swallowed and the scanner restarts.
          emit_a         = 1'b1;
          kind_a         = K_UNTERM;
          mode_next      = M_IDLE;
          tok_start_next = '0;
          tok_line_next  = LINE_BITS'(1);
          byte_pos_next  = '0;
          cur_line_next  = LINE_BITS'(1);
        end else begin
          byte_pos_next = pos_inc;
        end
      end
      M_DASH: begin
        emit_a    = 1'b1;
        mode_next = M_IDLE;
        if (in_byte == CH_GREATER) begin
          kind_a        = K_ARROW;
          len_a         = OFFSET_BITS'(2);
          byte_pos_next = pos_inc;
        end else begin
          kind_a = K_SINGLE;
          code_a = CH_DASH;
          len_a  = OFFSET_BITS'(1);
          fresh  = 1'b1;
        end
      end
      M_SLASH: begin
        if (in_byte == CH_SLASH) begin
          mode_next     = M_COMMENT;
          byte_pos_next = pos_inc;
        end else begin
          emit_a    = 1'b1;
          kind_a    = K_SINGLE;
          code_a    = CH_SLASH;
          len_a     = OFFSET_BITS'(1);
          mode_next = M_IDLE;
          fresh     = 1'b1;
        end
      end
      M_COMMENT: begin
        if ((in_byte == CH_NEWLINE) || (in_byte == CH_NUL)) begin
          mode_next = M_IDLE;
          fresh     = 1'b1;
        end else begin
          byte_pos_next = pos_inc;
        end
      end
      M_IDLE: begin
        fresh = 1'b1;
      end
    endcase

    // A fresh byte sees the unadvanced position, so no chaining of adders is needed.
    if (fresh) begin
      priority if (in_byte == CH_NUL) begin
        emit_b         = 1'b1;
        kind_b         = K_END;
        mode_next      = M_IDLE;
        tok_start_next = '0;
        tok_line_next  = LINE_BITS'(1);
        byte_pos_next  = '0;
        cur_line_next  = LINE_BITS'(1);
      end else if (is_space(in_byte)) begin
        if ((in_byte == CH_NEWLINE) && !(&cur_line)) begin
          cur_line_next = cur_line + LINE_BITS'(1);
        end
        byte_pos_next = pos_inc;
      end else if ((in_byte == CH_SLASH) || (in_byte == CH_DASH) || is_word(in_byte) ||
                   (in_byte == CH_HASH) || (in_byte == CH_QUOTE)) begin
        priority if (in_byte == CH_SLASH) begin
          mode_next = M_SLASH;
        end else if (in_byte == CH_DASH) begin
          mode_next = M_DASH;
        end else if (is_digit(in_byte)) begin
          mode_next = M_INT;
        end else if (is_word(in_byte)) begin
          mode_next = M_IDENT;
        end else if (in_byte == CH_HASH) begin
          mode_next = M_DIRECTIVE;
        end else begin
          mode_next = M_STRING;
        end
        tok_start_next = byte_pos;
        tok_line_next  = cur_line;
        byte_pos_next  = pos_inc;
      end else begin
        emit_b        = 1'b1;
        kind_b        = K_SINGLE;
        code_b        = in_byte;
        len_b         = OFFSET_BITS'(1);
        byte_pos_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      tok_start <= '0;
      tok_line  <= LINE_BITS'(1);
      byte_pos  <= '0;
      cur_line  <= LINE_BITS'(1);
    end else if (fire) begin
      mode      <= mode_next;
      tok_start <= tok_start_next;
      tok_line  <= tok_line_next;
      byte_pos  <= byte_pos_next;
      cur_line  <= cur_line_next;
    end
  end

  assign tok_a = pack_token(!emit_b, kind_a, code_a, tok_start, len_a, tok_line);
  assign tok_b = pack_token(1'b1, kind_b, code_b, byte_pos, len_b, cur_line);

  assign wr_count = fire ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
  assign wr_data0 = emit_a ? tok_a : tok_b;

  dbt_token_fifo #(
    .WIDTH (TW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr_data0 (wr_data0),
    .wr_data1 (tok_b),
    .rd_pop   (out_valid && !out_stall),
    .rd_valid (out_valid),
    .rd_data  (rd_data),
    .count    (fifo_count)
  );

  assign last         = rd_data[LAST_BIT];
  assign token_kind   = kind_t'(rd_data[LAST_BIT-1:KIND_LO]);
  assign char_code    = rd_data[KIND_LO-1:CODE_LO];
  assign start_offset = rd_data[CODE_LO-1:START_LO];
  assign token_length = rd_data[START_LO-1:LEN_LO];
  assign line_number  = rd_data[LEN_LO-1:0];

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= 3'd4)
    else $error("token queue count exceeds its depth");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && !room))
    else $error("input stalled without a blocked byte");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (fire && emit_b && (kind_b == K_END)) |=>
      ((byte_pos == '0) && (cur_line == LINE_BITS'(1)) && (mode == M_IDLE)))
    else $error("end token did not restart the scanner");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cur_line != '0) && (tok_line != '0))
    else $error("line counter reached zero");

endmodule

FILE: sv/dbt_token_fifo.sv
module dbt_token_fifo #(
  parameter int WIDTH = 76
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       wr_count,
  input  logic [WIDTH-1:0] wr_data0,
  input  logic [WIDTH-1:0] wr_data1,
  input  logic             rd_pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  output logic [2:0]       count
);

  localparam int DEPTH = 4;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [1:0]       wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + 2'd1;
  assign rd_valid     = (count != 3'd0);
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wr_ptr] <= wr_data0;
    end
    if (wr_count == 2'd2) begin
      mem[wr_ptr_plus1] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + wr_count;
      rd_ptr <= rd_ptr + {1'b0, rd_pop};
      count  <= count + {1'b0, wr_count} - {2'b00, rd_pop};
    end
  end

endmodule
